// File: rtl/legendre_coefficient_generator_top_defines.svh
// ----------------------------------------------------------------------------
// Legendre coefficient generator assertion macros
// Concurrent check wrappers; they expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef LEGENDRE_COEFFICIENT_GENERATOR_TOP_DEFINES_SVH
`define LEGENDRE_COEFFICIENT_GENERATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, clocked on clk, quiet in reset
`define LCG_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, clocked on clk, quiet in reset
`define LCG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LCG_ASSERT_IMPLY(label, ante, cons, msg)
`define LCG_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: rtl/lcg_pkg.sv
// ----------------------------------------------------------------------------
// Legendre coefficient generator package
// Widths, control words and the exact-division constant lookup.
// ----------------------------------------------------------------------------
package lcg_pkg;

    // Highest degree served; requests above it saturate
    localparam int MAX_DEGREE = 16;
    localparam int NUM_CELLS  = MAX_DEGREE + 1;

    // Field widths fixed by the interface
    localparam int DEG_W = 5;
    localparam int NUM_W = 33;

    // Exact numerators of degree d need about 2d+2 bits; never below the output
    localparam int ROW_W   = (2 * MAX_DEGREE + 2 > NUM_W + 1) ? 2 * MAX_DEGREE + 2 : NUM_W + 1;
    localparam int HALF_W  = ROW_W / 2;
    localparam int HI_W    = ROW_W - HALF_W;
    localparam int COEF_W  = DEG_W + 2;
    localparam int PROD_W  = ROW_W + COEF_W + 1;
    localparam int SHIFT_W = 3;

    // Per-round exact division by i: shift out 2^s, multiply by odd inverse
    typedef struct packed {
        logic [SHIFT_W-1:0] shift;
        logic [ROW_W-1:0]   inv;
    } div_entry_t;

    // Control word broadcast to every cell
    typedef struct packed {
        logic               init;
        logic               seed_one;
        logic               mul_en;
        logic               inv_en;
        logic               sum_en;
        logic               shift_out;
        logic [COEF_W-1:0]  a;
        logic [COEF_W-1:0]  b;
        logic [SHIFT_W-1:0] shift;
        logic [ROW_W-1:0]   inv;
    } cell_ctl_t;

    // Control of the output word register
    typedef struct packed {
        logic             load;
        logic [DEG_W-1:0] idx;
        logic             last;
    } out_ctl_t;

    // Constant lookup: each arm is folded at elaboration
    function automatic div_entry_t div_entry(input logic [DEG_W-1:0] idx);
        div_entry_t  e;
        logic [63:0] m;
        logic [63:0] x;
        int          s;
        e = '0;
        for (int j = 1; j <= MAX_DEGREE; j++) begin
            if (idx == DEG_W'(j)) begin
                s = 0;
                m = 64'(j);
                for (int t = 0; t < DEG_W; t++) begin
                    if (!m[0]) begin
                        m = m >> 1;
                        s = s + 1;
                    end
                end
                // Newton steps double the correct low bits of the inverse
                x = m;
                for (int t = 0; t < 5; t++) begin
                    x = x * (64'd2 - m * x);
                end
                e.shift = SHIFT_W'(s);
                e.inv   = x[ROW_W-1:0];
            end
        end
        return e;
    endfunction

endpackage

// File: rtl/lcg_cell.sv
// ----------------------------------------------------------------------------
// Legendre coefficient cell
// Holds one power's entry of the two previous rows and runs the recurrence
// for it; shifts its entry toward the head during readout.
// ----------------------------------------------------------------------------
module lcg_cell
    import lcg_pkg::*;
(
    input  logic             clk,
    input  cell_ctl_t        ctl,
    input  logic [ROW_W-1:0] seed_prev,
    input  logic [ROW_W-1:0] seed_before,
    input  logic [ROW_W-1:0] up_value,
    input  logic [ROW_W-1:0] down_value,
    output logic [ROW_W-1:0] prev_value
);

    logic [ROW_W-1:0]         prev_reg;
    logic [ROW_W-1:0]         prev_next;
    logic [ROW_W-1:0]         before_reg;
    logic [ROW_W-1:0]         before_next;
    logic signed [PROD_W-1:0] diff_reg;
    logic signed [PROD_W-1:0] diff_next;
    logic [ROW_W-1:0]         p0_reg;
    logic [ROW_W-1:0]         p0_next;
    logic [HI_W-1:0]          p1_reg;
    logic [HI_W-1:0]          p1_next;

    logic signed [PROD_W-1:0]    up_ext;
    logic signed [PROD_W-1:0]    before_ext;
    logic signed [PROD_W-1:0]    term_a;
    logic signed [PROD_W-1:0]    term_b;
    logic signed [PROD_W-1:0]    scaled;
    logic [ROW_W-1:0]            dividend;
    logic [ROW_W+HALF_W-1:0]     full0;
    logic [ROW_W+HI_W-1:0]       full1;
    logic [ROW_W-1:0]            quotient;

    // Scale the lower neighbor's previous-row entry and the cell's own older entry by the round coefficients
    always_comb
    begin
        up_ext     = {{(PROD_W - ROW_W){up_value[ROW_W-1]}}, up_value};
        before_ext = {{(PROD_W - ROW_W){before_reg[ROW_W-1]}}, before_reg};
        term_a     = $signed({1'b0, ctl.a}) * up_ext;
        term_b     = $signed({1'b0, ctl.b}) * before_ext;
    end

    // Exact divide: drop the power-of-two part, multiply by the odd inverse
    always_comb
    begin
        scaled   = diff_reg >>> ctl.shift;
        dividend = scaled[ROW_W-1:0];
        full0    = dividend * ctl.inv[HALF_W-1:0];
        full1    = dividend * ctl.inv[ROW_W-1:HALF_W];
        quotient = p0_reg + {p1_reg, {HALF_W{1'b0}}};
    end

    // Next values of the cell registers
    always_comb
    begin
        diff_next   = ctl.mul_en ? (term_a - term_b) : diff_reg;
        p0_next     = ctl.inv_en ? full0[ROW_W-1:0] : p0_reg;
        p1_next     = ctl.inv_en ? full1[HI_W-1:0] : p1_reg;
        prev_next   = prev_reg;
        before_next = before_reg;
        if (ctl.init)
        begin
            prev_next   = seed_prev;
            before_next = seed_before;
        end
        else if (ctl.sum_en)
        begin
            prev_next   = quotient;
            before_next = prev_reg;
        end
        else if (ctl.shift_out)
        begin
            prev_next = down_value;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg   <= prev_next;
        before_reg <= before_next;
        diff_reg   <= diff_next;
        p0_reg     <= p0_next;
        p1_reg     <= p1_next;
    end

    assign prev_value = prev_reg;

endmodule

// File: rtl/lcg_ctrl.sv
// ----------------------------------------------------------------------------
// Legendre coefficient sequencer
// Takes a degree, steps the cell row through the recurrence rounds and then
// through readout, one coefficient per output word.
// ----------------------------------------------------------------------------
`include "legendre_coefficient_generator_top_defines.svh"

module lcg_ctrl
    import lcg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             degree_valid,
    input  logic [DEG_W-1:0] degree,
    output logic             degree_ready,
    input  logic             out_free,
    output cell_ctl_t        cell_ctl,
    output out_ctl_t         out_ctl
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_INV  = 3'd2;
    localparam logic [2:0] S_SUM  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [DEG_W-1:0]  deg_reg;
    logic [DEG_W-1:0]  deg_next;
    logic [DEG_W-1:0]  round_reg;
    logic [DEG_W-1:0]  round_next;
    logic [DEG_W-1:0]  idx_reg;
    logic [DEG_W-1:0]  idx_next;
    logic [COEF_W-1:0] a_reg;
    logic [COEF_W-1:0] a_next;
    logic [COEF_W-1:0] b_reg;
    logic [COEF_W-1:0] b_next;
    div_entry_t        div_reg;
    div_entry_t        div_next;

    logic              accept;
    logic              load;
    logic [DEG_W-1:0]  deg_sat;
    logic [DEG_W-1:0]  round_sel;
    logic [COEF_W-1:0] round_x4;

    assign degree_ready = (state_reg == S_IDLE);
    assign accept       = degree_valid && degree_ready;
    assign load         = (state_reg == S_OUT) && out_free;
    assign deg_sat      = (degree > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : degree;

    // Round whose coefficients are staged next: the first on a new word
    assign round_sel = (state_reg == S_IDLE) ? DEG_W'(2) : round_reg + DEG_W'(1);
    assign round_x4  = {round_sel, 2'b00};

    // Sequence rounds, then readout
    always_comb
    begin
        state_next = state_reg;
        deg_next   = deg_reg;
        round_next = round_reg;
        idx_next   = idx_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        div_next   = div_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    deg_next   = deg_sat;
                    round_next = DEG_W'(2);
                    idx_next   = '0;
                    a_next     = round_x4 - COEF_W'(2);
                    b_next     = round_x4 - COEF_W'(4);
                    div_next   = div_entry(round_sel);
                    state_next = (deg_sat < DEG_W'(2)) ? S_OUT : S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_INV;
            end
            S_INV:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                if (round_reg == deg_reg)
                begin
                    idx_next   = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    round_next = round_sel;
                    a_next     = round_x4 - COEF_W'(2);
                    b_next     = round_x4 - COEF_W'(4);
                    div_next   = div_entry(round_sel);
                    state_next = S_MUL;
                end
            end
            S_OUT:
            begin
                if (load)
                begin
                    idx_next = idx_reg + DEG_W'(1);
                    if (idx_reg == deg_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            deg_reg   <= '0;
            round_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            deg_reg   <= deg_next;
            round_reg <= round_next;
            idx_reg   <= idx_next;
        end
    end

    // Round coefficients carry no reset
    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        div_reg <= div_next;
    end

    // Drive the cell row
    always_comb
    begin
        cell_ctl.init      = accept;
        cell_ctl.seed_one  = (deg_sat == '0);
        cell_ctl.mul_en    = (state_reg == S_MUL);
        cell_ctl.inv_en    = (state_reg == S_INV);
        cell_ctl.sum_en    = (state_reg == S_SUM);
        cell_ctl.shift_out = load;
        cell_ctl.a         = a_reg;
        cell_ctl.b         = b_reg;
        cell_ctl.shift     = div_reg.shift;
        cell_ctl.inv       = div_reg.inv;
    end

    assign out_ctl.load = load;
    assign out_ctl.idx  = idx_reg;
    assign out_ctl.last = (idx_reg == deg_reg);

    `LCG_ASSERT_IMPLY(a_round_range, (state_reg == S_MUL || state_reg == S_INV || state_reg == S_SUM), (round_reg >= DEG_W'(2) && round_reg <= deg_reg), "recurrence round outside 2..degree")
    `LCG_ASSERT_NEXT(a_last_round_reads_out, (state_reg == S_SUM && round_reg == deg_reg), (state_reg == S_OUT && idx_reg == '0), "final round did not start readout at power zero")
    `LCG_ASSERT_IMPLY(a_out_index_range, (state_reg == S_OUT), (idx_reg <= deg_reg && deg_reg <= DEG_W'(MAX_DEGREE)), "readout index beyond degree")

endmodule

// File: rtl/legendre_coefficient_generator_top.sv
// Degree 0 or 1 goes from acceptance straight to readout; degree n >= 2 first
// runs the recurrence rounds 2..n, each through multiply, inverse multiply and sum.
// Readout gives one word per cycle while the output register is free. A new degree
// is taken only after the last word of the one before has been loaded.
// Reset clears the sequencer and the output valid; row contents are rebuilt per word.
// ----------------------------------------------------------------------------
// Legendre coefficient generator
// Emits the exact numerators of P_n, lowest power first, over 2^n.
// ----------------------------------------------------------------------------
module legendre_coefficient_generator_top
    import lcg_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    degree_valid,
    output logic                    degree_ready,
    input  logic [DEG_W-1:0]        degree,
    output logic                    coefficient_valid,
    input  logic                    coefficient_ready,
    output logic signed [NUM_W-1:0] coefficient_numerator,
    output logic [DEG_W-1:0]        power_index,
    output logic                    last_coefficient
);

    localparam logic signed [ROW_W-1:0] NUM_HI = ROW_W'(64'sh0_FFFF_FFFF);
    localparam logic signed [ROW_W-1:0] NUM_LO = ROW_W'(-64'sh1_0000_0000);

    cell_ctl_t          cell_ctl;
    out_ctl_t           out_ctl;
    logic               out_free;
    logic [ROW_W-1:0]   prev_chain [NUM_CELLS];

    logic               valid_reg;
    logic               valid_next;
    logic [NUM_W-1:0]   num_reg;
    logic [NUM_W-1:0]   num_next;
    logic [DEG_W-1:0]   idx_reg;
    logic [DEG_W-1:0]   idx_next;
    logic               last_reg;
    logic               last_next;
    logic signed [ROW_W-1:0] head;
    logic [NUM_W-1:0]   head_clamped;

    assign out_free = !valid_reg || coefficient_ready;

    lcg_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .degree_valid (degree_valid),
        .degree       (degree),
        .degree_ready (degree_ready),
        .out_free     (out_free),
        .cell_ctl     (cell_ctl),
        .out_ctl      (out_ctl)
    );

    // Row of cells, one per power; the head feeds the output word
    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        logic [ROW_W-1:0] seed_prev;
        logic [ROW_W-1:0] seed_before;
        logic [ROW_W-1:0] up_value;
        logic [ROW_W-1:0] down_value;

        // Seed A_1 = 2x, A_0 = 1; degree zero reads A_0 from the head
        assign seed_prev   = (k == 0) ? ROW_W'(cell_ctl.seed_one) :
                             (k == 1) ? ROW_W'(2) : '0;
        assign seed_before = (k == 0) ? ROW_W'(1) : '0;
        assign up_value    = (k == 0) ? '0 : prev_chain[(k == 0) ? 0 : k - 1];
        assign down_value  = (k == NUM_CELLS - 1) ? '0 :
                             prev_chain[(k == NUM_CELLS - 1) ? k : k + 1];

        lcg_cell u_cell (
            .clk         (clk),
            .ctl         (cell_ctl),
            .seed_prev   (seed_prev),
            .seed_before (seed_before),
            .up_value    (up_value),
            .down_value  (down_value),
            .prev_value  (prev_chain[k])
        );
    end

    // Saturate the head entry to the output range
    always_comb
    begin
        head = prev_chain[0];
        if (head > NUM_HI)
        begin
            head_clamped = NUM_HI[NUM_W-1:0];
        end
        else if (head < NUM_LO)
        begin
            head_clamped = NUM_LO[NUM_W-1:0];
        end
        else
        begin
            head_clamped = head[NUM_W-1:0];
        end
    end

    // Output word register: load on a free slot, drop valid when taken
    always_comb
    begin
        valid_next = valid_reg;
        num_next   = num_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        if (out_ctl.load)
        begin
            valid_next = 1'b1;
            num_next   = head_clamped;
            idx_next   = out_ctl.idx;
            last_next  = out_ctl.last;
        end
        else if (coefficient_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        idx_reg  <= idx_next;
        last_reg <= last_next;
    end

    assign coefficient_valid     = valid_reg;
    assign coefficient_numerator = $signed(num_reg);
    assign power_index           = idx_reg;
    assign last_coefficient      = last_reg;

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// Legendre coefficient generator testbench
// Sends degree words, predicts the exact numerators of P_n by the Bonnet
// recurrence and checks every coefficient word in order, under random idling
// on both channels and in a phase without idling.
// ----------------------------------------------------------------------------
module tb_top
    import lcg_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  STALL_LIMIT  = 5000;
    localparam int  RANDOM_WORDS = 309;
    localparam int  NUM_PHASES   = 3;
    localparam int  DRAIN_CYCLES = 3 * MAX_DEGREE + 8;
    localparam longint NUM_HI    = (longint'(1) <<< (NUM_W - 1)) - 1;
    localparam longint NUM_LO    = -(longint'(1) <<< (NUM_W - 1));

    typedef struct packed {
        logic signed [NUM_W-1:0] numerator;
        logic [DEG_W-1:0]        power;
        logic                    last;
    } coefficient_word_t;

    // One directed row; typed rows carry their coefficients, the rest are predicted
    typedef struct packed {
        logic [DEG_W-1:0]        degree;
        logic                    typed;
        logic signed [NUM_W-1:0] num0;
        logic signed [NUM_W-1:0] num1;
    } degree_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    degree_valid;
    logic                    degree_ready;
    logic [DEG_W-1:0]        degree;
    logic                    coefficient_valid;
    logic                    coefficient_ready;
    logic signed [NUM_W-1:0] coefficient_numerator;
    logic [DEG_W-1:0]        power_index;
    logic                    last_coefficient;

    coefficient_word_t expected_coefficients[$];
    int send_idle_pct;
    int recv_idle_pct;
    int error_count;
    int degrees_sent;
    int degrees_saturated;
    int words_checked;

    // Directed degrees: both ends, every degree up to the top, saturation
    degree_row_t directed_rows [22] = '{
        '{5'd0,  1'b1, 33'sd1, 33'sd0},
        '{5'd1,  1'b1, 33'sd0, 33'sd2},
        '{5'd2,  1'b0, 33'sd0, 33'sd0},
        '{5'd3,  1'b0, 33'sd0, 33'sd0},
        '{5'd4,  1'b0, 33'sd0, 33'sd0},
        '{5'd5,  1'b0, 33'sd0, 33'sd0},
        '{5'd6,  1'b0, 33'sd0, 33'sd0},
        '{5'd7,  1'b0, 33'sd0, 33'sd0},
        '{5'd8,  1'b0, 33'sd0, 33'sd0},
        '{5'd9,  1'b0, 33'sd0, 33'sd0},
        '{5'd10, 1'b0, 33'sd0, 33'sd0},
        '{5'd11, 1'b0, 33'sd0, 33'sd0},
        '{5'd12, 1'b0, 33'sd0, 33'sd0},
        '{5'd13, 1'b0, 33'sd0, 33'sd0},
        '{5'd14, 1'b0, 33'sd0, 33'sd0},
        '{5'd15, 1'b0, 33'sd0, 33'sd0},
        '{5'd16, 1'b0, 33'sd0, 33'sd0},
        '{5'd17, 1'b0, 33'sd0, 33'sd0},
        '{5'd31, 1'b0, 33'sd0, 33'sd0},
        '{5'd24, 1'b0, 33'sd0, 33'sd0},
        '{5'd0,  1'b1, 33'sd1, 33'sd0},
        '{5'd1,  1'b1, 33'sd0, 33'sd2}
    };

    legendre_coefficient_generator_top u_dut (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .degree_valid          (degree_valid),
        .degree_ready          (degree_ready),
        .degree                (degree),
        .coefficient_valid     (coefficient_valid),
        .coefficient_ready     (coefficient_ready),
        .coefficient_numerator (coefficient_numerator),
        .power_index           (power_index),
        .last_coefficient      (last_coefficient)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Append one word to the tail of the expected queue
    function automatic void queue_expected_word(input coefficient_word_t w);
        expected_coefficients = {expected_coefficients, w};
    endfunction

    // Build the numerator rows A_i = 2^i * P_i and queue the words of the last one
    task automatic predict_legendre_row(input logic [DEG_W-1:0] req);
        longint older [NUM_CELLS];
        longint newer [NUM_CELLS];
        longint fresh [NUM_CELLS];
        longint up;
        longint keep;
        longint val;
        int     n;
        coefficient_word_t w;
        n = (int'(req) > MAX_DEGREE) ? MAX_DEGREE : int'(req);
        for (int k = 0; k < NUM_CELLS; k++)
        begin
            older[k] = 0;
            newer[k] = 0;
            fresh[k] = 0;
        end
        older[0] = 1;
        newer[1] = 2;
        for (int i = 2; i <= n; i++)
        begin
            for (int k = 0; k <= i; k++)
            begin
                up   = (k >= 1) ? newer[k-1] : 0;
                keep = (k + 2 <= i) ? older[k] : 0;
                fresh[k] = (longint'(2 * (2 * i - 1)) * up - longint'(4 * (i - 1)) * keep)
                           / longint'(i);
            end
            for (int k = i + 1; k < NUM_CELLS; k++)
            begin
                fresh[k] = 0;
            end
            older = newer;
            newer = fresh;
        end
        for (int k = 0; k <= n; k++)
        begin
            val = (n == 0) ? older[k] : newer[k];
            // Saturate to the output range
            if (val > NUM_HI)
                val = NUM_HI;
            else if (val < NUM_LO)
                val = NUM_LO;
            w.numerator = val[NUM_W-1:0];
            w.power     = DEG_W'(k);
            w.last      = (k == n);
            queue_expected_word(w);
        end
    endtask

    // Offer one degree word; hold it until taken, optionally drain results first
    task automatic send_degree(input logic [DEG_W-1:0] d, input bit drain_first);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (drain_first || gap > 0)
        begin
            degree_valid <= 1'b0;
            if (drain_first)
            begin
                do
                    @(posedge clk);
                while (expected_coefficients.size() != 0);
            end
            repeat (gap) @(posedge clk);
        end
        degree_valid <= 1'b1;
        degree       <= d;
        do
            @(posedge clk);
        while (!degree_ready);
        degrees_sent++;
        if (int'(d) > MAX_DEGREE)
            degrees_saturated++;
    endtask

    // Stimulus and end of run
    initial
    begin
        coefficient_word_t w;
        logic [DEG_W-1:0]  d;
        rst_n             = 1'b0;
        degree_valid      = 1'b0;
        degree            = '0;
        send_idle_pct     = 7;
        recv_idle_pct     = 82;
        error_count       = 0;
        degrees_sent      = 0;
        degrees_saturated = 0;
        words_checked     = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (directed_rows[r])
        begin
            send_degree(directed_rows[r].degree, 1'b0);
            if (directed_rows[r].typed)
            begin
                for (int k = 0; k <= int'(directed_rows[r].degree); k++)
                begin
                    w.numerator = (k == 0) ? directed_rows[r].num0 : directed_rows[r].num1;
                    w.power     = DEG_W'(k);
                    w.last      = (k == int'(directed_rows[r].degree));
                    queue_expected_word(w);
                end
            end
            else
            begin
                predict_legendre_row(directed_rows[r].degree);
            end
        end

        // Random degrees in three idling phases, draining before each
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            send_idle_pct = (p == 0) ? 7 : (p == 1) ? 82 : 0;
            recv_idle_pct = (p == 0) ? 82 : (p == 1) ? 7 : 0;
            for (int j = 0; j < RANDOM_WORDS / NUM_PHASES; j++)
            begin
                if ($urandom_range(0, 9) == 0)
                    d = DEG_W'($urandom_range(MAX_DEGREE + 1, (1 << DEG_W) - 1));
                else
                    d = DEG_W'($urandom_range(0, MAX_DEGREE));
                send_degree(d, j == 0);
                predict_legendre_row(d);
            end
        end
        degree_valid <= 1'b0;

        // Wait out the last results, then watch for strays
        while (expected_coefficients.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_coefficients.size() != 0)
        begin
            $error("%0d coefficient words never arrived", expected_coefficients.size());
            error_count++;
        end

        $display("sent %0d degrees (%0d saturated), checked %0d coefficient words",
                 degrees_sent, degrees_saturated, words_checked);
        $display("idling: sender-light, receiver-light and no idling phases");
        if (error_count == 0)
            $display("legendre_coefficient_generator_top: match");
        else
            $display("legendre_coefficient_generator_top: mismatch");
        $finish;
    end

    // Take coefficient words and compare each against the oldest expectation
    initial
    begin
        coefficient_ready = 1'b0;
    end

    always @(posedge clk)
    begin
        coefficient_word_t w;
        if (rst_n && coefficient_valid && coefficient_ready)
        begin
            if (expected_coefficients.size() == 0)
            begin
                $error("unexpected coefficient word: numerator %0d power %0d last %0d",
                       coefficient_numerator, power_index, last_coefficient);
                error_count++;
            end
            else
            begin
                w = expected_coefficients.pop_front();
                words_checked++;
                if (coefficient_numerator !== w.numerator)
                begin
                    $error("coefficient_numerator: expected %0d, got %0d",
                           w.numerator, coefficient_numerator);
                    error_count++;
                end
                if (power_index !== w.power)
                begin
                    $error("power_index: expected %0d, got %0d", w.power, power_index);
                    error_count++;
                end
                if (last_coefficient !== w.last)
                begin
                    $error("last_coefficient: expected %0d, got %0d",
                           w.last, last_coefficient);
                    error_count++;
                end
            end
        end
        coefficient_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Stop the run when no word moves for too long
    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (degree_valid && degree_ready)
                || (coefficient_valid && coefficient_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("legendre_coefficient_generator_top: mismatch");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/lcg_pkg.sv
rtl/lcg_cell.sv
rtl/lcg_ctrl.sv
rtl/legendre_coefficient_generator_top.sv
dv/tb_top.sv
